[hw/rtl/hfop_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hfop_pkg
// Shared types, codes and constants of the heater force-on policy block.
// ----------------------------------------------------------------------------
package hfop_pkg;

   localparam int ZONES         = 4;
   localparam int MS_PER_MINUTE = 60000;
   localparam int TEMP_BITS     = 16;

   localparam int TEMP_W     = 16;
   localparam int NOW_W      = 32;
   localparam int MIN_W      = 8;
   localparam int MS_W       = $clog2(MS_PER_MINUTE + 1);
   localparam int ZIDX_W     = 2;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;

   typedef enum logic [1:0] {
      ACT_KEEP = 2'd0,
      ACT_ON   = 2'd1,
      ACT_OFF  = 2'd2
   } action_type;

   localparam logic [1:0] FS_OFF  = 2'd0;
   localparam logic [1:0] FS_ON   = 2'd1;
   localparam logic [1:0] FS_AUTO = 2'd2;

   localparam logic [1:0] OPM_RUN   = 2'd0;
   localparam logic [1:0] OPM_TIMED = 2'd1;
   localparam logic [1:0] OPM_STOP  = 2'd2;
   localparam logic [1:0] OPM_OTHER = 2'd3;

   localparam logic [REG_IDX_W-1:0] REG_FORCE_SETTING  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PERIOD_MINUTES = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_DURATION_MIN   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_ACTIVE_THRESH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OFF_THRESH     = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PERIODIC_THRESH = 3'd5;

   typedef struct packed {
      logic [1:0]       force_setting;
      logic [MIN_W-1:0] period_minutes;
      logic [MIN_W-1:0] duration_minutes;
   } cfg_type;

   typedef struct packed {
      logic cold;
      logic below_periodic;
   } lane_type;

   typedef struct packed {
      logic              found;
      logic [ZIDX_W-1:0] index;
      logic              below_periodic;
   } scan_type;

   typedef struct packed {
      action_type        action;
      logic              low_reason;
      logic              found;
      logic [ZIDX_W-1:0] index;
   } result_type;

endpackage
`default_nettype wire

[hw/rtl/hfop_zone_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hfop_zone_lane
// One zone: signed compare of the temperature against its mode threshold
// and its periodic threshold.
// ----------------------------------------------------------------------------
module hfop_zone_lane (
   input  wire logic [hfop_pkg::TEMP_W-1:0] temp,
   input  wire logic [hfop_pkg::TEMP_W-1:0] mode_thresh,
   input  wire logic [hfop_pkg::TEMP_W-1:0] periodic_thresh,
   output hfop_pkg::lane_type               lane
);
   import hfop_pkg::*;

   logic signed [TEMP_BITS-1:0] t_s;
   logic signed [TEMP_BITS-1:0] m_s;
   logic signed [TEMP_BITS-1:0] p_s;

   assign t_s = $signed(temp[TEMP_BITS-1:0]);
   assign m_s = $signed(mode_thresh[TEMP_BITS-1:0]);
   assign p_s = $signed(periodic_thresh[TEMP_BITS-1:0]);

   assign lane.cold           = t_s < m_s;
   assign lane.below_periodic = t_s < p_s;

endmodule
`default_nettype wire

[hw/rtl/hfop_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hfop_merge
// Combine the zone lanes: first cold zone and any zone below periodic.
// ----------------------------------------------------------------------------
module hfop_merge (
   input  wire hfop_pkg::lane_type [hfop_pkg::ZONES-1:0] lanes,
   input  wire logic                                     mode_ok,
   output hfop_pkg::scan_type                            scan
);
   import hfop_pkg::*;

   always_comb begin
      scan.found          = 1'b0;
      scan.index          = '0;
      scan.below_periodic = 1'b0;
      for (int z = ZONES - 1; z >= 0; z--) begin
         if (lanes[z].cold && mode_ok) begin
            scan.found = 1'b1;
            scan.index = ZIDX_W'(z);
         end
         if (lanes[z].below_periodic) begin
            scan.below_periodic = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[hw/rtl/hfop_policy.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hfop_policy
// Activity tracking, forced-run state and the force decision for one beat.
// ----------------------------------------------------------------------------
module hfop_policy (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [hfop_pkg::NOW_W-1:0] now_ms,
   input  wire logic [1:0]                 op_mode,
   input  wire logic                       heater_active,
   input  wire hfop_pkg::scan_type         scan,
   input  wire hfop_pkg::cfg_type          cfg,
   output hfop_pkg::result_type            result
);
   import hfop_pkg::*;

   logic             was_active_ff, was_active_in;
   logic [NOW_W-1:0] last_change_ff, last_change_in;
   logic             run_forced_ff, run_forced_in;
   logic             run_cancelled_ff, run_cancelled_in;
   logic [1:0]       mode_at_force_ff, mode_at_force_in;

   logic [NOW_W-1:0]      elapsed;
   logic [MS_W+MIN_W-1:0] period_ms;
   logic [MS_W+MIN_W-1:0] duration_ms;
   logic                  periodic;
   logic                  keep;

   assign period_ms   = (MS_W+MIN_W)'(cfg.period_minutes) * (MS_W+MIN_W)'(MS_PER_MINUTE);
   assign duration_ms = (MS_W+MIN_W)'(cfg.duration_minutes) * (MS_W+MIN_W)'(MS_PER_MINUTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         was_active_ff    <= 1'b0;
         last_change_ff   <= '0;
         run_forced_ff    <= 1'b0;
         run_cancelled_ff <= 1'b0;
         mode_at_force_ff <= OPM_RUN;
      end else if (accept) begin
         was_active_ff    <= was_active_in;
         last_change_ff   <= last_change_in;
         run_forced_ff    <= run_forced_in;
         run_cancelled_ff <= run_cancelled_in;
         mode_at_force_ff <= mode_at_force_in;
      end
   end

   always_comb begin
      was_active_in    = heater_active;
      last_change_in   = (heater_active != was_active_ff) ? now_ms : last_change_ff;
      run_forced_in    = run_forced_ff;
      run_cancelled_in = run_cancelled_ff;
      mode_at_force_in = mode_at_force_ff;
      elapsed          = now_ms - last_change_in;
      keep             = 1'b0;

      periodic = !heater_active && !scan.found && (cfg.period_minutes != '0)
               && (cfg.duration_minutes != '0) && scan.below_periodic
               && (elapsed >= NOW_W'(period_ms));

      result.action     = ACT_OFF;
      result.low_reason = 1'b0;
      result.found      = scan.found;
      result.index      = scan.index;

      case (cfg.force_setting)
         FS_ON: begin
            result.action = ACT_ON;
         end
         FS_AUTO: begin
            if (!heater_active && scan.found) begin
               result.action     = ACT_ON;
               result.low_reason = 1'b1;
            end else if (periodic) begin
               result.action = ACT_ON;
            end else if (heater_active) begin
               result.action = ACT_KEEP;
               if (!run_cancelled_ff) begin
                  keep = elapsed < NOW_W'(duration_ms);
                  if (keep) begin
                     if (!run_forced_ff) begin
                        mode_at_force_in = op_mode;
                     end else if (mode_at_force_ff != op_mode) begin
                        keep             = 1'b0;
                        run_cancelled_in = 1'b1;
                     end
                  end
                  run_forced_in = keep;
                  result.action = keep ? ACT_KEEP : ACT_OFF;
               end
            end else begin
               run_forced_in    = 1'b0;
               run_cancelled_in = 1'b0;
               result.action    = ACT_OFF;
            end
         end
         default: begin
            result.action = ACT_OFF;
         end
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/heater_force_on_policy.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// heater_force_on_policy
// Per-tick heater force-on decision with zone scan and APB-style registers.
// ----------------------------------------------------------------------------
// Each accepted tick yields exactly one result beat. A tick is evaluated in
// the cycle it is accepted: four zone compare lanes, a merge of their flags
// and the policy state update all settle in that one cycle, so the block
// takes one tick per clock unless the skid register is full. Results pass
// through an output register backed by a one-beat skid register; req_ready
// drops only while that is full. Registers sit at byte address 8*i, 64 bits
// wide; after reset all CSRs and policy state are zero, no clearing pass needed.
// ----------------------------------------------------------------------------
module heater_force_on_policy (
   input  wire logic                            clock,
   input  wire logic                            reset,

   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [31:0]                     req_now_ms,
   input  wire logic [1:0]                      req_op_mode,
   input  wire logic                            req_heater_active,
   input  wire logic signed [15:0]              req_zone_temp_0,
   input  wire logic signed [15:0]              req_zone_temp_1,
   input  wire logic signed [15:0]              req_zone_temp_2,
   input  wire logic signed [15:0]              req_zone_temp_3,

   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [1:0]                           rsp_force_action,
   output logic                                 rsp_temp_low_reason,
   output logic                                 rsp_cold_zone_found,
   output logic [1:0]                           rsp_cold_zone_index,

   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [hfop_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [hfop_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [hfop_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);
   import hfop_pkg::*;

   logic [1:0]            force_setting_ff;
   logic [MIN_W-1:0]      period_ff;
   logic [MIN_W-1:0]      duration_ff;
   logic [CSR_DATA_W-1:0] active_th_ff;
   logic [CSR_DATA_W-1:0] off_th_ff;
   logic [CSR_DATA_W-1:0] periodic_th_ff;

   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  csr_write;

   cfg_type               cfg;
   logic [TEMP_W-1:0]     temps [4];
   logic [CSR_DATA_W-1:0] mode_th_word;
   logic                  mode_ok;
   lane_type [ZONES-1:0]  lanes;
   scan_type              scan;
   result_type            result;

   logic                  accept;
   logic                  pop;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   result_type            rsp_data_ff, rsp_data_in;
   result_type            skid_data_ff, skid_data_in;

   // register port
   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         force_setting_ff <= FS_OFF;
         period_ff        <= '0;
         duration_ff      <= '0;
         active_th_ff     <= '0;
         off_th_ff        <= '0;
         periodic_th_ff   <= '0;
      end else if (csr_write) begin
         case (reg_idx)
            REG_FORCE_SETTING:   force_setting_ff <= pwdata[1:0];
            REG_PERIOD_MINUTES:  period_ff        <= pwdata[MIN_W-1:0];
            REG_DURATION_MIN:    duration_ff      <= pwdata[MIN_W-1:0];
            REG_ACTIVE_THRESH:   active_th_ff     <= pwdata;
            REG_OFF_THRESH:      off_th_ff        <= pwdata;
            REG_PERIODIC_THRESH: periodic_th_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FORCE_SETTING:   prdata = CSR_DATA_W'(force_setting_ff);
         REG_PERIOD_MINUTES:  prdata = CSR_DATA_W'(period_ff);
         REG_DURATION_MIN:    prdata = CSR_DATA_W'(duration_ff);
         REG_ACTIVE_THRESH:   prdata = active_th_ff;
         REG_OFF_THRESH:      prdata = off_th_ff;
         REG_PERIODIC_THRESH: prdata = periodic_th_ff;
         default:             prdata = '0;
      endcase
   end

   assign cfg.force_setting    = force_setting_ff;
   assign cfg.period_minutes   = period_ff;
   assign cfg.duration_minutes = duration_ff;

   // zone lanes
   assign temps[0] = req_zone_temp_0;
   assign temps[1] = req_zone_temp_1;
   assign temps[2] = req_zone_temp_2;
   assign temps[3] = req_zone_temp_3;

   assign mode_th_word = (req_op_mode == OPM_STOP) ? off_th_ff : active_th_ff;
   assign mode_ok      = (req_op_mode != OPM_OTHER);

   for (genvar z = 0; z < ZONES; z++) begin : g_lane
      hfop_zone_lane u_lane (
         .temp            (temps[z]),
         .mode_thresh     (mode_th_word[TEMP_W*z +: TEMP_W]),
         .periodic_thresh (periodic_th_ff[TEMP_W*z +: TEMP_W]),
         .lane            (lanes[z])
      );
   end

   hfop_merge u_merge (
      .lanes   (lanes),
      .mode_ok (mode_ok),
      .scan    (scan)
   );

   hfop_policy u_policy (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .now_ms        (req_now_ms),
      .op_mode       (req_op_mode),
      .heater_active (req_heater_active),
      .scan          (scan),
      .cfg           (cfg),
      .result        (result)
   );

   // output register and skid
   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = rsp_valid_ff && rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || pop) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_force_action    = rsp_data_ff.action;
   assign rsp_temp_low_reason = rsp_data_ff.low_reason;
   assign rsp_cold_zone_found = rsp_data_ff.found;
   assign rsp_cold_zone_index = rsp_data_ff.index;

   a_skid_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid beat held without an output beat");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !skid_valid_ff && !accept) |=> !rsp_valid_ff)
      else $error("output beat not dropped after it was taken");

   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.found) |-> (rsp_data_ff.index == '0))
      else $error("cold zone index set without a cold zone");

   a_low_reason: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.low_reason)
      |-> (rsp_data_ff.found && (rsp_data_ff.action == ACT_ON)))
      else $error("low temperature reason without a forced-on cold zone");

endmodule
`default_nettype wire

[test/tb_heater_force_on_policy.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heater_force_on_policy
// Self-checking bench for the heater force-on policy block. A driver feeds
// check ticks from a queue. A decision model predicts each result at the
// beat where the block takes the tick, and a monitor compares the result
// beats in order. Phases step through the force settings, the period and
// duration extremes and several threshold sets. Ticks follow a directed
// sequence and random well-formed timelines with some noise.
// Both channels idle at random, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_heater_force_on_policy;
   import hfop_pkg::*;

   localparam logic [1:0] FS_UNDEFINED = 2'd3;
   localparam int         STALL_LIMIT  = 5000;
   localparam int         HOLD_CYCLES  = 120;

   typedef struct packed {
      logic [31:0]      now_ms;
      logic [1:0]       op_mode;
      logic             heater_active;
      logic [3:0][15:0] temps;
   } tick_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_now_ms = '0;
   logic [1:0]            req_op_mode = OPM_RUN;
   logic                  req_heater_active = 1'b0;
   logic signed [15:0]    req_zone_temp_0 = '0;
   logic signed [15:0]    req_zone_temp_1 = '0;
   logic signed [15:0]    req_zone_temp_2 = '0;
   logic signed [15:0]    req_zone_temp_3 = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_force_action;
   logic                  rsp_temp_low_reason;
   logic                  rsp_cold_zone_found;
   logic [1:0]            rsp_cold_zone_index;

   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // decision model: register copy and policy state
   logic [1:0]  cfg_force = FS_OFF;
   logic [7:0]  cfg_period = '0;
   logic [7:0]  cfg_duration = '0;
   logic [63:0] thr_active = '0;
   logic [63:0] thr_off = '0;
   logic [63:0] thr_periodic = '0;
   logic        heater_was_on = 1'b0;
   logic [31:0] change_stamp_ms = '0;
   logic        run_held = 1'b0;
   logic        run_dropped = 1'b0;
   logic [1:0]  run_mode = OPM_RUN;

   tick_type   ticks_waiting[$];
   result_type decisions_due[$];
   tick_type   tick_on_bus;
   result_type due;

   int          ticks_queued = 0;
   int          decisions_checked = 0;
   int          err_count = 0;
   int          quiet_cycles = 0;
   int          hold_asked = 0;
   int          hold_taken = 0;
   int          hold_left = 0;
   logic        steady = 1'b0;
   logic [31:0] sim_now = '0;
   logic [1:0]  gen_mode = OPM_RUN;
   logic        gen_active = 1'b0;

   heater_force_on_policy u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_now_ms          (req_now_ms),
      .req_op_mode         (req_op_mode),
      .req_heater_active   (req_heater_active),
      .req_zone_temp_0     (req_zone_temp_0),
      .req_zone_temp_1     (req_zone_temp_1),
      .req_zone_temp_2     (req_zone_temp_2),
      .req_zone_temp_3     (req_zone_temp_3),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_force_action    (rsp_force_action),
      .rsp_temp_low_reason (rsp_temp_low_reason),
      .rsp_cold_zone_found (rsp_cold_zone_found),
      .rsp_cold_zone_index (rsp_cold_zone_index),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic result_type predict_decision(input tick_type tk);
      logic [63:0] thr;
      logic        has_thr;
      logic        found;
      logic [1:0]  idx;
      logic        below_per;
      logic        periodic;
      logic        keep;
      logic [31:0] elapsed;
      result_type  r;
      found     = 1'b0;
      idx       = 2'd0;
      below_per = 1'b0;
      if (tk.heater_active != heater_was_on) begin
         change_stamp_ms = tk.now_ms;
         heater_was_on   = tk.heater_active;
      end
      has_thr = 1'b1;
      thr     = thr_active;
      if (tk.op_mode == OPM_STOP) begin
         thr = thr_off;
      end else if (tk.op_mode == OPM_OTHER) begin
         has_thr = 1'b0;
      end
      for (int i = 3; i >= 0; i--) begin
         if (has_thr && $signed(tk.temps[i]) < $signed(thr[16*i +: 16])) begin
            found = 1'b1;
            idx   = i[1:0];
         end
         if ($signed(tk.temps[i]) < $signed(thr_periodic[16*i +: 16]))
            below_per = 1'b1;
      end
      elapsed      = tk.now_ms - change_stamp_ms;
      r.action     = ACT_OFF;
      r.low_reason = 1'b0;
      r.found      = found;
      r.index      = idx;
      if (cfg_force == FS_ON) begin
         r.action = ACT_ON;
      end else if (cfg_force == FS_AUTO) begin
         periodic = !heater_was_on && !found && cfg_period != 0 && cfg_duration != 0 &&
                    below_per && elapsed >= 32'(cfg_period) * 32'(MS_PER_MINUTE);
         if (!heater_was_on && found) begin
            r.action     = ACT_ON;
            r.low_reason = 1'b1;
         end else if (periodic) begin
            r.action = ACT_ON;
         end else if (heater_was_on) begin
            r.action = ACT_KEEP;
            if (!run_dropped) begin
               keep = elapsed < 32'(cfg_duration) * 32'(MS_PER_MINUTE);
               if (keep) begin
                  if (!run_held) begin
                     run_mode = tk.op_mode;
                  end else if (run_mode != tk.op_mode) begin
                     keep        = 1'b0;
                     run_dropped = 1'b1;
                  end
               end
               run_held = keep;
               r.action = keep ? ACT_KEEP : ACT_OFF;
            end
         end else begin
            run_held    = 1'b0;
            run_dropped = 1'b0;
            r.action    = ACT_OFF;
         end
      end
      return r;
   endfunction

   function automatic logic [15:0] near_threshold(input int z);
      logic [63:0] base;
      int          sel;
      sel  = $urandom_range(2);
      base = (sel == 0) ? thr_active : (sel == 1) ? thr_off : thr_periodic;
      if ($urandom_range(99) < 15)
         return 16'($urandom);
      return base[16*z +: 16] + 16'($urandom_range(8)) - 16'd2;
   endfunction

   task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FORCE_SETTING:   cfg_force    = value[1:0];
         REG_PERIOD_MINUTES:  cfg_period   = value[7:0];
         REG_DURATION_MIN:    cfg_duration = value[7:0];
         REG_ACTIVE_THRESH:   thr_active   = value;
         REG_OFF_THRESH:      thr_off      = value;
         REG_PERIODIC_THRESH: thr_periodic = value;
         default: ;
      endcase
   endtask

   task automatic set_policy(input logic [1:0] force_sel, input logic [7:0] period,
                             input logic [7:0] duration, input logic [63:0] act,
                             input logic [63:0] off, input logic [63:0] per);
      write_reg(REG_FORCE_SETTING, 64'(force_sel));
      write_reg(REG_PERIOD_MINUTES, 64'(period));
      write_reg(REG_DURATION_MIN, 64'(duration));
      write_reg(REG_ACTIVE_THRESH, act);
      write_reg(REG_OFF_THRESH, off);
      write_reg(REG_PERIODIC_THRESH, per);
   endtask

   task automatic put_tick(input logic [31:0] t, input logic [1:0] m, input logic a,
                           input logic [15:0] z0, input logic [15:0] z1,
                           input logic [15:0] z2, input logic [15:0] z3);
      tick_type tk;
      tk.now_ms        = t;
      tk.op_mode       = m;
      tk.heater_active = a;
      tk.temps         = {z3, z2, z1, z0};
      ticks_waiting.push_back(tk);
      ticks_queued++;
      sim_now    = t;
      gen_mode   = m;
      gen_active = a;
   endtask

   // well-formed timelines with some noise: time mostly moves forward, activity and mode change now and then
   task automatic queue_ticks(input int count);
      tick_type tk;
      int       unit;
      int       pick;
      unit = ((cfg_period > cfg_duration ? int'(cfg_period) : int'(cfg_duration)) + 1) *
             MS_PER_MINUTE;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            tk.now_ms        = $urandom;
            tk.op_mode       = 2'($urandom_range(3));
            tk.heater_active = 1'($urandom);
            tk.temps         = {$urandom, $urandom};
            sim_now          = tk.now_ms;
         end else begin
            pick = $urandom_range(99);
            if (pick < 55)
               sim_now = sim_now + $urandom_range(3000);
            else if (pick < 95)
               sim_now = sim_now + $urandom_range(2 * unit);
            else
               sim_now = sim_now + $urandom;
            if ($urandom_range(99) < 12)
               gen_active = !gen_active;
            if ($urandom_range(99) < 8)
               gen_mode = 2'($urandom_range(3));
            tk.now_ms        = sim_now;
            tk.op_mode       = gen_mode;
            tk.heater_active = gen_active;
            for (int z = 0; z < 4; z++)
               tk.temps[z] = near_threshold(z);
         end
         ticks_waiting.push_back(tk);
         ticks_queued++;
      end
   endtask

   task automatic drain;
      while (decisions_checked != ticks_queued) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: force off
      queue_ticks(20);
      drain();

      // directed pass through the automatic policy
      set_policy(FS_AUTO, 8'd1, 8'd2, 64'h0, 64'hFF9C_FF9C_FF9C_FF9C,
                 64'h0032_0032_0032_0032);
      put_tick(32'd1000, OPM_RUN, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      put_tick(32'd2000, OPM_RUN, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      put_tick(32'd3000, OPM_RUN, 1'b0, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF);
      put_tick(32'd3000, OPM_TIMED, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      put_tick(32'd4000, OPM_RUN, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      put_tick(32'd62000, OPM_STOP, 1'b0, 16'hFFCE, 16'hFFCE, 16'hFFCE, 16'hFFCE);
      put_tick(32'd62000, OPM_STOP, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFF00);
      put_tick(32'd63000, OPM_OTHER, 1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      put_tick(32'd64000, OPM_OTHER, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      put_tick(32'd80000, OPM_RUN, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'd100000, OPM_RUN, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'd110000, OPM_TIMED, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'd120000, OPM_RUN, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'd130000, OPM_RUN, 1'b0, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'd131000, OPM_RUN, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'd251000, OPM_RUN, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'd260000, OPM_RUN, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
      put_tick(32'hFFFF_F000, OPM_STOP, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      put_tick(32'h0000_E000, OPM_STOP, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      put_tick(32'hFFFF_FFFF, OPM_RUN, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      put_tick(32'h0000_0000, OPM_RUN, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      drain();

      set_policy(FS_AUTO, 8'd1, 8'd1, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
      queue_ticks(200);
      drain();

      // longest period and run, no idling on either side
      steady = 1'b1;
      set_policy(FS_AUTO, 8'd255, 8'd255, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                 64'h7FFF_7FFF_7FFF_7FFF);
      queue_ticks(90);
      drain();
      steady = 1'b0;

      set_policy(FS_ON, 8'd4, 8'd7, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom});
      queue_ticks(60);
      drain();

      write_reg(REG_FORCE_SETTING, 64'(FS_UNDEFINED));
      queue_ticks(40);
      drain();

      set_policy(FS_AUTO, 8'd0, 8'd5, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
                 64'h0064_0064_0064_0064);
      queue_ticks(90);
      drain();

      set_policy(FS_AUTO, 8'd3, 8'd0, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF,
                 {$urandom, $urandom});
      queue_ticks(90);
      drain();

      // hold the result side off while ticks keep coming
      set_policy(FS_AUTO, 8'd2, 8'd2, 64'h8000_8000_8000_8000, {$urandom, $urandom},
                 64'h0000_0010_FFF0_0000);
      hold_asked++;
      queue_ticks(120);
      drain();

      write_reg(REG_FORCE_SETTING, 64'(FS_OFF));
      queue_ticks(20);
      drain();

      if (decisions_due.size() != 0) begin
         $error("%0d expected results never arrived", decisions_due.size());
         err_count++;
      end
      if (err_count == 0)
         $display("tb_heater_force_on_policy: done, clean");
      else
         $display("tb_heater_force_on_policy: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            decisions_due.push_back(predict_decision(tick_on_bus));
         if (!req_valid || req_ready) begin
            if (ticks_waiting.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
               tick_on_bus = ticks_waiting.pop_front();
               req_now_ms        <= tick_on_bus.now_ms;
               req_op_mode       <= tick_on_bus.op_mode;
               req_heater_active <= tick_on_bus.heater_active;
               req_zone_temp_0   <= tick_on_bus.temps[0];
               req_zone_temp_1   <= tick_on_bus.temps[1];
               req_zone_temp_2   <= tick_on_bus.temps[2];
               req_zone_temp_3   <= tick_on_bus.temps[3];
               req_valid         <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= steady || $urandom_range(99) >= 14;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (decisions_due.size() == 0) begin
            $error("result beat with no tick waiting for it");
            err_count++;
         end else begin
            due = decisions_due.pop_front();
            if (rsp_force_action != due.action) begin
               $error("force_action: expected %0d, got %0d", due.action, rsp_force_action);
               err_count++;
            end
            if (rsp_temp_low_reason != due.low_reason) begin
               $error("temp_low_reason: expected %0d, got %0d", due.low_reason,
                      rsp_temp_low_reason);
               err_count++;
            end
            if (rsp_cold_zone_found != due.found) begin
               $error("cold_zone_found: expected %0d, got %0d", due.found,
                      rsp_cold_zone_found);
               err_count++;
            end
            if (rsp_cold_zone_index != due.index) begin
               $error("cold_zone_index: expected %0d, got %0d", due.index,
                      rsp_cold_zone_index);
               err_count++;
            end
            decisions_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_heater_force_on_policy: done, errors");
            $finish;
         end
      end
   end

endmodule

[heater_force_on_policy.f]
hw/rtl/hfop_pkg.sv
hw/rtl/hfop_zone_lane.sv
hw/rtl/hfop_merge.sv
hw/rtl/hfop_policy.sv
hw/rtl/heater_force_on_policy.sv
test/tb_heater_force_on_policy.sv
